// ----- rtl/dts_pkg.sv -----
// ----------------------------------------------------------------------------
// dts_pkg
// Shared types and constants for the DDS tuning-word serializer.
// ----------------------------------------------------------------------------
package dts_pkg;

    localparam int WORD_BITS_DEF = 32;

    localparam int FREQ_W  = 28;
    localparam int PHASE_W = 16;
    localparam int CTRL_W  = 3;
    localparam int CLK_W   = 28;
    localparam int DEN_W   = 31;   // clock times six fits in 31 bits
    localparam int STEP_W  = 5;
    localparam int TAIL_W  = 8;

    localparam logic [CLK_W-1:0] CLK_RESET = 28'd30000000;

    // floor(phase / 1125) = (phase * ceil(2^26 / 1125)) >> 26 for any 16-bit phase
    localparam int PHASE_SHIFT = 26;
    localparam int PROD_W      = PHASE_W + 16;
    localparam logic [15:0] PHASE_RECIP = 16'd59653;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    // One classified item, as handed from the front to the back.
    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [DEN_W-1:0]  den;
        logic              sat;
        logic [TAIL_W-1:0] tail;
    } dts_job_t;

endpackage

// ----- rtl/dts_front.sv -----
// ----------------------------------------------------------------------------
// dts_front
// Input stage: accept an item, form the divisor, quantize phase, flag saturation.
// ----------------------------------------------------------------------------
module dts_front
    import dts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [FREQ_W-1:0] freq_hz,
    input  logic [PHASE_W-1:0] phase_centideg,
    input  logic [CTRL_W-1:0] control_bits,
    input  logic [CLK_W-1:0]  clock_hz,
    input  logic              q_full,
    output logic              q_wr,
    output dts_job_t          q_data
);

    logic                valid_reg;
    logic [FREQ_W-1:0]   freq_reg;
    logic [PHASE_W-1:0]  angle_reg;
    logic [CTRL_W-1:0]   ctrl_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [DEN_W-1:0]    den_next;
    logic                accept;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-PHASE_SHIFT-1:0] quo;
    logic [STEP_W-1:0]   step;

    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign q_wr   = valid_reg && !q_full;

    // x6 as (x << 2) + (x << 1)
    assign den_next = control_bits[0]
                    ? (DEN_W'({clock_hz, 2'b00}) + DEN_W'({clock_hz, 1'b0}))
                    : DEN_W'(clock_hz);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (q_wr)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            freq_reg  <= freq_hz;
            angle_reg <= phase_centideg;
            ctrl_reg  <= control_bits;
            den_reg   <= den_next;
        end
    end

    assign prod = {16'b0, angle_reg} * {{(PROD_W-16){1'b0}}, PHASE_RECIP};
    assign quo  = prod[PROD_W-1:PHASE_SHIFT];
    // a full turn or more maps to step zero
    assign step = quo[STEP_W] ? '0 : quo[STEP_W-1:0];

    always_comb
    begin
        q_data.freq = freq_reg;
        q_data.den  = den_reg;
        q_data.sat  = (den_reg == '0) || ({3'b000, freq_reg} >= den_reg);
        q_data.tail = {step, ctrl_reg};
    end

endmodule

// ----- rtl/dts_fifo.sv -----
// ----------------------------------------------------------------------------
// dts_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module dts_fifo
    import dts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  dts_job_t wr_data,
    input  logic     rd_en,
    output dts_job_t rd_data,
    output logic     full,
    output logic     empty
);

    dts_job_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W:0]   count_reg;
    logic                  do_wr;
    logic                  do_rd;

    assign full  = (count_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;

    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH-1)) ? '0
                            : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH-1)) ? '0
                            : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/dts_div.sv -----
// ----------------------------------------------------------------------------
// dts_div
// Restoring divider: one quotient bit per cycle, then the all-ones correction.
// ----------------------------------------------------------------------------
module dts_div
    import dts_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    output logic                 job_pop,
    input  dts_job_t             job,
    output logic                 res_valid,
    input  logic                 res_take,
    output logic [WORD_BITS-1:0] res_word,
    output logic [TAIL_W-1:0]    res_tail
);

    localparam int CNT_W = $clog2(WORD_BITS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIX,
        S_DONE
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [FREQ_W-1:0]    freq_reg;
    logic [WORD_BITS-1:0] q_reg;
    logic [TAIL_W-1:0]    tail_reg;
    logic [DEN_W:0]       rem_sh;
    logic                 fits;

    assign job_pop   = (state_reg == S_IDLE) && job_valid;
    assign res_valid = (state_reg == S_DONE);
    assign res_word  = q_reg;
    assign res_tail  = tail_reg;

    assign rem_sh = {rem_reg, 1'b0};
    assign fits   = (rem_sh >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            den_reg   <= '0;
            freq_reg  <= '0;
            q_reg     <= '0;
            tail_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        den_reg  <= job.den;
                        freq_reg <= job.freq;
                        rem_reg  <= DEN_W'(job.freq);
                        tail_reg <= job.tail;
                        cnt_reg  <= '0;
                        if (job.sat)
                        begin
                            q_reg     <= {WORD_BITS{1'b1}};
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            q_reg     <= '0;
                            state_reg <= S_RUN;
                        end
                    end
                end
                S_RUN:
                begin
                    rem_reg <= fits ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
                    q_reg   <= {q_reg[WORD_BITS-2:0], fits};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(WORD_BITS-1))
                    begin
                        state_reg <= S_FIX;
                    end
                end
                S_FIX:
                begin
                    // subtract freq/den: borrow one when the remainder fell below freq
                    if ((rem_reg < DEN_W'(freq_reg)) && (q_reg != '0))
                    begin
                        q_reg <= q_reg - 1'b1;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (res_take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/dts_ser.sv -----
// ----------------------------------------------------------------------------
// dts_ser
// Output shifter: emit the load word one bit per transaction, LSB first.
// ----------------------------------------------------------------------------
module dts_ser
    import dts_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_valid,
    output logic                 res_take,
    input  logic [WORD_BITS-1:0] res_word,
    input  logic [TAIL_W-1:0]    res_tail,
    output logic                 empty,
    input  logic                 pop,
    output logic                 serial_bit,
    output logic                 first_bit,
    output logic                 last_bit
);

    localparam int TOTAL = WORD_BITS + TAIL_W;
    localparam int CNT_W = $clog2(TOTAL);

    logic                 busy_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [TOTAL-1:0]     sh_reg;
    logic                 adv;
    logic                 load;

    assign empty      = !busy_reg;
    assign serial_bit = sh_reg[0];
    assign first_bit  = (cnt_reg == '0);
    assign last_bit   = (cnt_reg == CNT_W'(TOTAL-1));

    assign adv      = pop && busy_reg;
    // reload on the cycle the last bit leaves so items run back to back
    assign load     = res_valid && (!busy_reg || (adv && last_bit));
    assign res_take = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (adv)
        begin
            if (last_bit)
            begin
                busy_reg <= 1'b0;
                cnt_reg  <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sh_reg <= {res_tail, res_word};
        end
        else if (adv)
        begin
            sh_reg <= {1'b0, sh_reg[TOTAL-1:1]};
        end
    end

endmodule

// ----- rtl/dds_tuning_word_serializer.sv -----
// ----------------------------------------------------------------------------
// dds_tuning_word_serializer
// Compute a DDS frequency tuning word and phase byte and stream the load word.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     push / full          freq_hz[27:0], phase_centideg[15:0], control_bits[2:0]
//  result    empty / pop          serial_bit, first_bit, last_bit
//  config    cfg_write            cfg_data[27:0] (reference clock in Hz)
//
//  Each input transaction yields WORD_BITS + 8 result transactions (40 by
//  default); with pop held high the output shifter, not the divider, limits
//  the item rate. The divider works on the next item while the shifter
//  drains the current one; a saturated word skips the division.
//  A two-entry queue and the input register let push proceed while pop stalls.
//  Reset empties every stage and loads the clock register with 30 MHz.
// ----------------------------------------------------------------------------
module dds_tuning_word_serializer
    import dts_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // input queue side
    input  logic               push,
    output logic               full,
    input  logic [FREQ_W-1:0]  freq_hz,
    input  logic [PHASE_W-1:0] phase_centideg,
    input  logic [CTRL_W-1:0]  control_bits,
    // result queue side
    output logic               empty,
    input  logic               pop,
    output logic               serial_bit,
    output logic               first_bit,
    output logic               last_bit,
    // configuration
    input  logic               cfg_write,
    input  logic [CLK_W-1:0]   cfg_data
);

    logic [CLK_W-1:0]     clock_hz_reg;

    logic                 q_full;
    logic                 q_empty;
    logic                 q_wr;
    logic                 q_rd;
    dts_job_t             q_wdata;
    dts_job_t             q_rdata;

    logic                 res_valid;
    logic                 res_take;
    logic [WORD_BITS-1:0] res_word;
    logic [TAIL_W-1:0]    res_tail;

    // Hold the reference clock; the user must write it only while the block is idle (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg <= CLK_RESET;
        end
        else if (cfg_write)
        begin
            clock_hz_reg <= cfg_data;
        end
    end

    // Front: register the item, form the divisor, quantize phase.
    dts_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .freq_hz        (freq_hz),
        .phase_centideg (phase_centideg),
        .control_bits   (control_bits),
        .clock_hz       (clock_hz_reg),
        .q_full         (q_full),
        .q_wr           (q_wr),
        .q_data         (q_wdata)
    );

    // Decouple classification from the long division.
    dts_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wdata),
        .rd_en   (q_rd),
        .rd_data (q_rdata),
        .full    (q_full),
        .empty   (q_empty)
    );

    // Back, part one: one quotient bit per cycle.
    dts_div #(
        .WORD_BITS (WORD_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!q_empty),
        .job_pop   (q_rd),
        .job       (q_rdata),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res_word  (res_word),
        .res_tail  (res_tail)
    );

    // Back, part two: stream word then control/phase byte, LSB first.
    dts_ser #(
        .WORD_BITS (WORD_BITS)
    ) u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res_word   (res_word),
        .res_tail   (res_tail),
        .empty      (empty),
        .pop        (pop),
        .serial_bit (serial_bit),
        .first_bit  (first_bit),
        .last_bit   (last_bit)
    );

endmodule
